>>> rtl/crc32rd_pkg.sv
// ----------------------------------------------------------------------------
// crc32rd_pkg
// Shared types, event codes and helper functions of the record stream deframer.
// ----------------------------------------------------------------------------
package crc32rd_pkg;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_BLOCK_OK  = 4'd1;
  localparam logic [3:0] EV_DONE      = 4'd2;
  localparam logic [3:0] EV_BAD_SIG   = 4'd3;
  localparam logic [3:0] EV_BAD_HDR   = 4'd4;
  localparam logic [3:0] EV_BAD_CRC   = 4'd5;
  localparam logic [3:0] EV_MISPLACED = 4'd6;
  localparam logic [3:0] EV_BAD_FOOT  = 4'd7;
  localparam logic [3:0] EV_TRUNC     = 4'd8;
  localparam logic [3:0] EV_TRAILING  = 4'd9;
  localparam logic [3:0] EV_OVERFLOW  = 4'd10;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_META   = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_PAY_RST  = 32'd33554432;
  localparam logic [63:0] COUNT_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFE;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic [1:0] block_kind;
    logic       payload_last;
    logic [3:0] event_code;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0:    v = 8'h50;
      4'd1:    v = 8'h53;
      4'd2:    v = 8'h52;
      4'd3:    v = 8'h45;
      4'd4:    v = 8'h43;
      4'd5:    v = 8'h0D;
      4'd6:    v = 8'h0A;
      4'd7:    v = 8'h1A;
      4'd8:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

>>> rtl/crc32rd_front.sv
// ----------------------------------------------------------------------------
// crc32rd_front
// Input side: accepts stream beats, tags end markers and queues them.
// ----------------------------------------------------------------------------
module crc32rd_front
  import crc32rd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  logic     in_action,
  input  logic [7:0] in_data_byte,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  in_item_t   q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      // Data is irrelevant on an end marker; clear it so it never leaks.
      q_r[wr_ptr_r].is_end <= in_action;
      q_r[wr_ptr_r].data   <= in_action ? 8'd0 : in_data_byte;
    end
  end

endmodule

>>> rtl/crc32rd_parser.sv
// ----------------------------------------------------------------------------
// crc32rd_parser
// Back side: signature check, block parsing, CRC and the result queue.
// ----------------------------------------------------------------------------
module crc32rd_parser
  import crc32rd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] max_payload,
  input  logic        item_valid,
  input  in_item_t    item,
  output logic        item_take,
  output logic        out_empty,
  input  logic        out_pop,
  output result_t     out_res
);

  localparam logic [2:0] PH_SIG     = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC     = 3'd3;
  localparam logic [2:0] PH_TAIL    = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_FAIL    = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] type_r, type_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] size_r, size_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [63:0] rc_r, rc_nxt;
  logic [63:0] foot_r, foot_nxt;
  logic        sigbad_r, sigbad_nxt;
  logic        meta_r, meta_nxt;

  result_t     q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        res_valid;
  result_t     res;
  logic        do_pop;

  logic [7:0]  b;
  logic [31:0] pos_inc;
  logic [63:0] seq_full, exp_seq;
  logic [31:0] rcv_full, crc_upd;

  assign item_take = item_valid && (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_res   = q_r[rd_ptr_r];
  assign do_pop    = out_pop && !out_empty;

  assign b        = item.data;
  assign pos_inc  = pos_r + 32'd1;
  assign seq_full = {b, seq_r[55:0]};
  assign exp_seq  = meta_r ? rc_r + 64'd1 : 64'd0;
  assign rcv_full = {b, rcv_r[23:0]};
  assign crc_upd  = crc_byte(crc_r, b);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    kind_nxt   = kind_r;
    size_nxt   = size_r;
    seq_nxt    = seq_r;
    crc_nxt    = crc_r;
    rcv_nxt    = rcv_r;
    rc_nxt     = rc_r;
    foot_nxt   = foot_r;
    sigbad_nxt = sigbad_r;
    meta_nxt   = meta_r;
    res_valid  = 1'b0;
    res        = '0;
    if (item_take && phase_r != PH_DONE && phase_r != PH_FAIL) begin
      if (item.is_end) begin
        res_valid = 1'b1;
        if (phase_r == PH_TAIL) begin
          phase_nxt       = PH_DONE;
          res.block_kind  = KIND_END;
          res.event_code  = EV_DONE;
        end else begin
          phase_nxt       = PH_FAIL;
          res.event_code  = EV_TRUNC;
        end
      end else begin
        unique case (phase_r)
          PH_SIG: begin
            if (b != sig_byte(pos_r[3:0])) sigbad_nxt = 1'b1;
            pos_nxt = pos_inc;
            if (pos_r[3:0] == 4'd11) begin
              if (sigbad_nxt) begin
                phase_nxt      = PH_FAIL;
                res_valid      = 1'b1;
                res.event_code = EV_BAD_SIG;
              end else begin
                phase_nxt = PH_PREFIX;
                pos_nxt   = 32'd0;
              end
            end
          end
          PH_PREFIX: begin
            crc_nxt = crc_upd;
            pos_nxt = pos_inc;
            if (pos_r[3:2] == 2'd0)      type_nxt[8*pos_r[1:0] +: 8] = b;
            else if (pos_r[3:2] == 2'd1) size_nxt[8*pos_r[1:0] +: 8] = b;
            else                         seq_nxt[8*pos_r[2:0] +: 8]  = b;
            kind_nxt = type_r[1:0];
            if (pos_r[3:0] == 4'd15) begin
              pos_nxt = 32'd0;
              if (seq_full != exp_seq || size_r > max_payload ||
                  type_r == 32'd0 || type_r > 32'd3) begin
                phase_nxt      = PH_FAIL;
                res_valid      = 1'b1;
                res.event_code = EV_BAD_HDR;
              end else begin
                phase_nxt = (size_r != 32'd0) ? PH_PAYLOAD : PH_CRC;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_nxt = crc_upd;
            pos_nxt = pos_inc;
            if (kind_r == KIND_END && pos_r < 32'd8) foot_nxt[8*pos_r[2:0] +: 8] = b;
            if (pos_inc >= size_r) begin
              phase_nxt = PH_CRC;
              pos_nxt   = 32'd0;
            end
            if (kind_r == KIND_META || kind_r == KIND_RECORD) begin
              res_valid        = 1'b1;
              res.byte_valid   = 1'b1;
              res.payload_byte = b;
              res.block_kind   = kind_r;
              res.payload_last = (pos_inc >= size_r);
              res.event_code   = EV_NONE;
            end
          end
          PH_CRC: begin
            rcv_nxt[8*pos_r[1:0] +: 8] = b;
            pos_nxt = pos_inc;
            if (pos_r[1:0] == 2'd3) begin
              priority if (rcv_full != ~crc_r) begin
                phase_nxt = PH_FAIL; res_valid = 1'b1; res.event_code = EV_BAD_CRC;
              end else if (!meta_r && kind_r != KIND_META) begin
                phase_nxt = PH_FAIL; res_valid = 1'b1; res.event_code = EV_MISPLACED;
              end else if (kind_r == KIND_END) begin
                if (size_r != 32'd8 || foot_r != rc_r) begin
                  phase_nxt = PH_FAIL; res_valid = 1'b1; res.event_code = EV_BAD_FOOT;
                end else begin
                  phase_nxt = PH_TAIL;
                end
              end else if (meta_r && kind_r != KIND_RECORD) begin
                phase_nxt = PH_FAIL; res_valid = 1'b1; res.event_code = EV_MISPLACED;
              end else if (meta_r && rc_r == COUNT_LIMIT) begin
                phase_nxt = PH_FAIL; res_valid = 1'b1; res.event_code = EV_OVERFLOW;
              end else begin
                // Good metadata or record block: count a record block and start the next one.
                if (meta_r) rc_nxt = rc_r + 64'd1;
                meta_nxt       = 1'b1;
                res_valid      = 1'b1;
                res.block_kind = kind_r;
                res.event_code = EV_BLOCK_OK;
                phase_nxt      = PH_PREFIX;
                pos_nxt        = 32'd0;
                type_nxt       = 32'd0;
                size_nxt       = 32'd0;
                seq_nxt        = 64'd0;
                crc_nxt        = CRC_INIT;
                rcv_nxt        = 32'd0;
                foot_nxt       = 64'd0;
              end
            end
          end
          PH_TAIL: begin
            phase_nxt      = PH_FAIL;
            res_valid      = 1'b1;
            res.event_code = EV_TRAILING;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      pos_r    <= 32'd0;
      type_r   <= 32'd0;
      kind_r   <= KIND_NONE;
      size_r   <= 32'd0;
      seq_r    <= 64'd0;
      crc_r    <= CRC_INIT;
      rcv_r    <= 32'd0;
      rc_r     <= 64'd0;
      foot_r   <= 64'd0;
      sigbad_r <= 1'b0;
      meta_r   <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      kind_r   <= kind_nxt;
      size_r   <= size_nxt;
      seq_r    <= seq_nxt;
      crc_r    <= crc_nxt;
      rcv_r    <= rcv_nxt;
      rc_r     <= rc_nxt;
      foot_r   <= foot_nxt;
      sigbad_r <= sigbad_nxt;
      meta_r   <= meta_nxt;
      if (res_valid) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)    rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, res_valid} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) q_r[wr_ptr_r] <= res;
  end

endmodule

>>> rtl/crc32_record_stream_deframer.sv
// ----------------------------------------------------------------------------
// crc32_record_stream_deframer
// Checks a signed, CRC-protected block stream and emits payload bytes/status.
// ----------------------------------------------------------------------------
// Channel  Handshake          Carries
// in_      push / full        action, data_byte
// out_     empty / pop        byte_valid, payload_byte, block_kind, last, event
// cfg_     valid / ready      max_payload_bytes (always ready)
//
// One beat per cycle sustained while the out_ side is popped; the parser's
// per-byte path is bounded by the CRC update and header field capture.
// A result passes through the registered input queue and output queue.
// Two-entry queues on input and output let either side stall independently.
// Synchronous active-low reset returns to the signature phase.
// ----------------------------------------------------------------------------
module crc32_record_stream_deframer
  import crc32rd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_byte_valid,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_block_kind,
  output logic        out_payload_last,
  output logic [3:0]  out_event_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_payload_bytes
);

  logic [31:0] max_pay_r;
  logic        item_valid, item_take;
  in_item_t    item;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pay_r <= MAX_PAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_pay_r <= cfg_max_payload_bytes;
    end
  end

  crc32rd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  crc32rd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_payload (max_pay_r),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_res     (res)
  );

  assign out_byte_valid   = res.byte_valid;
  assign out_payload_byte = res.payload_byte;
  assign out_block_kind   = res.block_kind;
  assign out_payload_last = res.payload_last;
  assign out_event_code   = res.event_code;

  a_byte_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_byte_valid) |-> (out_event_code == EV_NONE))
    else $error("payload beat carries an event code");

  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_payload_last) |-> out_byte_valid)
    else $error("payload_last without a payload byte");

  a_err_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code > EV_DONE) |-> (out_block_kind == KIND_NONE))
    else $error("error event carries a block kind");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives one long framed byte stream through the record stream deframer:
// signature, metadata, many records under several payload size limits, then
// a randomly chosen ending (clean end or one kind of error). Every accepted
// result is compared field by field against an in-bench predictor or typed-in values.
// ----------------------------------------------------------------------------
module testbench;
  import crc32rd_pkg::*;

  typedef enum logic [2:0] {
    ST_SIG, ST_PREFIX, ST_PAYLOAD, ST_CRC, ST_TAIL, ST_DONE, ST_FAIL
  } parse_state_e;

  typedef enum logic [2:0] {
    TG_RAW, TG_FIRST, TG_CRC0, TG_CRC1, TG_CRC2, TG_CRC3
  } row_tag_e;

  typedef struct {
    logic       act;
    logic [7:0] data;
    row_tag_e   tag;
    bit         typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_R = '0;
  localparam int      IDLE_LIMIT = 3000;
  localparam int      HOLD_CYCLES = 90;
  localparam logic [7:0] SIG_SEQ [12] = '{8'h50, 8'h53, 8'h52, 8'h45, 8'h43, 8'h0D,
                                         8'h0A, 8'h1A, 8'h01, 8'h00, 8'h00, 8'h00};

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_action;
  logic [7:0]  in_data_byte;
  logic        out_empty;
  logic        out_pop;
  logic        out_byte_valid;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_block_kind;
  logic        out_payload_last;
  logic [3:0]  out_event_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_max_payload_bytes;

  crc32_record_stream_deframer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_action             (in_action),
    .in_data_byte          (in_data_byte),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_byte_valid        (out_byte_valid),
    .out_payload_byte      (out_payload_byte),
    .out_block_kind        (out_block_kind),
    .out_payload_last      (out_payload_last),
    .out_event_code        (out_event_code),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_payload_bytes (cfg_max_payload_bytes)
  );

  // Predictor state.
  parse_state_e st;
  logic [31:0]  pos;
  logic [31:0]  blk_type;
  logic [31:0]  pay_size;
  logic [63:0]  blk_seq;
  logic [31:0]  crc_acc;
  logic [31:0]  crc_rx;
  logic [63:0]  rec_count;
  logic [63:0]  footer;
  logic [31:0]  size_limit;
  bit           failed;
  bit           stream_done;
  bit           sig_bad;
  bit           meta_seen;

  result_t      expected_beats [$];
  int           errors;
  int           beats_sent;
  logic [63:0]  records_sent;
  bit           calm;
  bit           hold_req;
  int           idle_cycles;

  stim_row_t directed_rows [] = '{
    '{1'b0, 8'h50, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h53, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h52, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h45, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h43, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h0D, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h0A, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h1A, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h01, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    // Metadata block, sequence 0, two payload bytes at the byte extremes.
    '{1'b0, 8'h01, TG_FIRST, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h02, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b1, '{1'b1, 8'h00, KIND_META, 1'b0, EV_NONE}},
    '{1'b0, 8'hFF, TG_RAW, 1'b1, '{1'b1, 8'hFF, KIND_META, 1'b1, EV_NONE}},
    '{1'b0, 8'h00, TG_CRC0, 1'b0, NO_R}, '{1'b0, 8'h00, TG_CRC1, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_CRC2, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_CRC3, 1'b1, '{1'b0, 8'h00, KIND_META, 1'b0, EV_BLOCK_OK}},
    // Record block, sequence 1, one payload byte.
    '{1'b0, 8'h02, TG_FIRST, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h01, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h01, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R}, '{1'b0, 8'h00, TG_RAW, 1'b0, NO_R},
    '{1'b0, 8'h80, TG_RAW, 1'b1, '{1'b1, 8'h80, KIND_RECORD, 1'b1, EV_NONE}},
    '{1'b0, 8'h00, TG_CRC0, 1'b0, NO_R}, '{1'b0, 8'h00, TG_CRC1, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_CRC2, 1'b0, NO_R},
    '{1'b0, 8'h00, TG_CRC3, 1'b1, '{1'b0, 8'h00, KIND_RECORD, 1'b0, EV_BLOCK_OK}}
  };

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    end
    return r;
  endfunction

  task automatic new_block();
    st       = ST_PREFIX;
    pos      = '0;
    blk_type = '0;
    pay_size = '0;
    blk_seq  = '0;
    crc_acc  = 32'hFFFF_FFFF;
    crc_rx   = '0;
    footer   = '0;
  endtask

  function automatic result_t fail_with(input logic [3:0] ev);
    result_t r;
    r = '0;
    r.event_code = ev;
    failed = 1'b1;
    st = ST_FAIL;
    return r;
  endfunction

  task automatic deframe_predict(input logic act, input logic [7:0] b,
                                 output bit has, output result_t r);
    logic [63:0] want_seq;
    has = 1'b0;
    r = '0;
    if (failed || stream_done) return;
    if (act) begin
      has = 1'b1;
      if (st == ST_TAIL) begin
        stream_done = 1'b1;
        st = ST_DONE;
        r.block_kind = KIND_END;
        r.event_code = EV_DONE;
      end else begin
        r = fail_with(EV_TRUNC);
      end
      return;
    end
    case (st)
      ST_SIG: begin
        if (b != SIG_SEQ[pos]) sig_bad = 1'b1;
        pos = pos + 1;
        if (pos >= 12) begin
          if (sig_bad) begin
            has = 1'b1;
            r = fail_with(EV_BAD_SIG);
          end else begin
            new_block();
          end
        end
      end
      ST_PREFIX: begin
        crc_acc = crc_next(crc_acc, b);
        if (pos < 4) blk_type[8*pos +: 8] = b;
        else if (pos < 8) pay_size[8*(pos-4) +: 8] = b;
        else blk_seq[8*(pos-8) +: 8] = b;
        pos = pos + 1;
        if (pos >= 16) begin
          want_seq = meta_seen ? rec_count + 1 : 64'd0;
          if (blk_seq != want_seq || pay_size > size_limit || blk_type < 1 || blk_type > 3) begin
            has = 1'b1;
            r = fail_with(EV_BAD_HDR);
          end else begin
            pos = '0;
            st = (pay_size != 0) ? ST_PAYLOAD : ST_CRC;
          end
        end
      end
      ST_PAYLOAD: begin
        crc_acc = crc_next(crc_acc, b);
        if (blk_type == 3 && pos < 8) footer[8*pos +: 8] = b;
        pos = pos + 1;
        if (blk_type == 1 || blk_type == 2) begin
          has = 1'b1;
          r.byte_valid = 1'b1;
          r.payload_byte = b;
          r.block_kind = blk_type[1:0];
          r.payload_last = (pos >= pay_size);
        end
        if (pos >= pay_size) begin
          st = ST_CRC;
          pos = '0;
        end
      end
      ST_CRC: begin
        crc_rx[8*pos +: 8] = b;
        pos = pos + 1;
        if (pos >= 4) begin
          if (crc_rx != ~crc_acc) begin
            has = 1'b1;
            r = fail_with(EV_BAD_CRC);
          end else if (!meta_seen) begin
            has = 1'b1;
            if (blk_type != 1) begin
              r = fail_with(EV_MISPLACED);
            end else begin
              meta_seen = 1'b1;
              new_block();
              r.block_kind = KIND_META;
              r.event_code = EV_BLOCK_OK;
            end
          end else if (blk_type == 3) begin
            if (pay_size != 8 || footer != rec_count) begin
              has = 1'b1;
              r = fail_with(EV_BAD_FOOT);
            end else begin
              st = ST_TAIL;
            end
          end else begin
            has = 1'b1;
            if (blk_type != 2) begin
              r = fail_with(EV_MISPLACED);
            end else if (rec_count == COUNT_LIMIT) begin
              r = fail_with(EV_OVERFLOW);
            end else begin
              rec_count = rec_count + 1;
              new_block();
              r.block_kind = KIND_RECORD;
              r.event_code = EV_BLOCK_OK;
            end
          end
        end
      end
      ST_TAIL: begin
        has = 1'b1;
        r = fail_with(EV_TRAILING);
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sends one beat; the expectation comes from the predictor unless typed in.
  task automatic send_beat(input logic act, input logic [7:0] d,
                           input bit typed, input result_t want);
    bit      has;
    result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_action    <= act;
    in_data_byte <= d;
    do @(posedge clk); while (in_full);
    deframe_predict(act, d, has, r);
    if (typed) expected_beats = {expected_beats, want};
    else if (has) expected_beats = {expected_beats, r};
    beats_sent++;
  endtask

  task automatic send_block(input logic [31:0] typ, input logic [31:0] size,
                            input logic [63:0] seq, input logic [63:0] foot,
                            input bit bad_crc, input bit hdr_only);
    logic [127:0] hdr;
    logic [31:0]  c;
    logic [7:0]   d;
    hdr = {seq, size, typ};
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < 16; i++) begin
      c = crc_next(c, hdr[8*i +: 8]);
      send_beat(1'b0, hdr[8*i +: 8], 1'b0, NO_R);
    end
    if (hdr_only) return;
    for (int j = 0; j < size; j++) begin
      d = (typ == 3 && j < 8) ? foot[8*j +: 8] : 8'($urandom);
      c = crc_next(c, d);
      send_beat(1'b0, d, 1'b0, NO_R);
    end
    c = ~c;
    if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) send_beat(1'b0, c[8*k +: 8], 1'b0, NO_R);
  endtask

  function automatic logic [31:0] pick_size(input logic [31:0] lim);
    int          roll;
    logic [31:0] top;
    roll = $urandom_range(0, 15);
    top = (roll < 10) ? 4 : (roll < 15) ? 12 : 40;
    if (top > lim) top = lim;
    return (roll == 15) ? top : $urandom_range(0, top);
  endfunction

  task automatic send_record();
    records_sent = records_sent + 1;
    send_block(2, pick_size(size_limit), records_sent, 64'd0, 1'b0, 1'b0);
  endtask

  // The sender stops pushing and waits until every expected result is back.
  task automatic drain();
    in_push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_valid             <= 1'b1;
    cfg_max_payload_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    size_limit  = v;
  endtask

  initial begin
    logic [31:0] txc;
    logic [7:0]  d;
    int          ending;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_action = 1'b0;
    in_data_byte = '0;
    cfg_valid = 1'b0;
    cfg_max_payload_bytes = '0;
    errors = 0;
    beats_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    new_block();
    st = ST_SIG;
    rec_count = '0;
    size_limit = MAX_PAY_RST;
    failed = 1'b0;
    stream_done = 1'b0;
    sig_bad = 1'b0;
    meta_seen = 1'b0;
    txc = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(32'hFFFF_FFFF);

    foreach (directed_rows[i]) begin
      d = directed_rows[i].data;
      case (directed_rows[i].tag)
        TG_FIRST: txc = crc_next(32'hFFFF_FFFF, d);
        TG_CRC0:  d = ~txc[7:0];
        TG_CRC1:  d = ~txc[15:8];
        TG_CRC2:  d = ~txc[23:16];
        TG_CRC3:  d = ~txc[31:24];
        default:  txc = crc_next(txc, d);
      endcase
      send_beat(directed_rows[i].act, d, directed_rows[i].typed, directed_rows[i].want);
    end
    records_sent = 1;

    // A long receiver stall while the stream keeps coming.
    hold_req = 1'b1;
    while (beats_sent < 200) send_record();
    drain();
    write_limit(32'd0);
    repeat (3) send_record();
    drain();
    write_limit(32'd5);
    while (beats_sent < 330) send_record();
    drain();
    write_limit(MAX_PAY_RST);
    calm = 1'b1;
    while (beats_sent < 430) send_record();

    ending = $urandom_range(0, 7);
    case (ending)
      0, 1: begin
        send_block(3, 8, records_sent + 1, records_sent, 1'b0, 1'b0);
        send_beat(ending == 0, 8'($urandom), 1'b0, NO_R);
      end
      2: send_block(3, 8, records_sent + 1, records_sent + 1, 1'b0, 1'b0);
      3: send_block(2, pick_size(size_limit), records_sent + 1, 64'd0, 1'b1, 1'b0);
      4: send_block(2, size_limit + 1, records_sent + 1, 64'd0, 1'b0, 1'b1);
      5: begin
        send_block(2, 3, records_sent + 1, 64'd0, 1'b0, 1'b1);
        send_beat(1'b1, 8'($urandom), 1'b0, NO_R);
      end
      6: send_block(1, pick_size(size_limit), records_sent + 1, 64'd0, 1'b0, 1'b0);
      default: send_block(2, 2, records_sent + 2, 64'd0, 1'b0, 1'b1);
    endcase
    // The block is stopped now; these beats must be ignored.
    repeat (4) send_beat(1'($urandom), 8'($urandom), 1'b0, NO_R);
    in_push <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  task automatic check_beat();
    result_t w;
    if (expected_beats.size() == 0) begin
      $error("unexpected result: event_code %0d", out_event_code);
      errors++;
      return;
    end
    w = expected_beats.pop_front();
    if (out_byte_valid !== w.byte_valid) begin
      $error("byte_valid expected %0d got %0d", w.byte_valid, out_byte_valid);
      errors++;
    end
    if (out_payload_byte !== w.payload_byte) begin
      $error("payload_byte expected %0d got %0d", w.payload_byte, out_payload_byte);
      errors++;
    end
    if (out_block_kind !== w.block_kind) begin
      $error("block_kind expected %0d got %0d", w.block_kind, out_block_kind);
      errors++;
    end
    if (out_payload_last !== w.payload_last) begin
      $error("payload_last expected %0d got %0d", w.payload_last, out_payload_last);
      errors++;
    end
    if (out_event_code !== w.event_code) begin
      $error("event_code expected %0d got %0d", w.event_code, out_event_code);
      errors++;
    end
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) check_beat();
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_pop <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Ends a run in which no beat moves on either side for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
rtl/crc32rd_pkg.sv
rtl/crc32rd_front.sv
rtl/crc32rd_parser.sv
rtl/crc32_record_stream_deframer.sv
bench/testbench.sv
